// ===== rtl/tdq_pkg.sv =====
package tdq_pkg;

    localparam int ID_W       = 4;
    localparam int INTERVAL_W = 31;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;

    localparam logic [CMD_W-1:0] CMD_ARM    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISARM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_COMPACT,
        CELL_APPEND,
        CELL_MARK
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_COMPACT,
        ST_APPEND,
        ST_MARK,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [TIME_W-1:0]     deadline;
        logic [INTERVAL_W-1:0] interval;
        logic                  periodic;
        logic                  due;
    } entry_t;

    typedef struct packed {
        logic                  valid;
        logic [TIME_W-1:0]     age;
        logic [ID_W-1:0]       id;
        logic [INTERVAL_W-1:0] interval;
        logic                  periodic;
    } tok_t;

    typedef struct packed {
        cell_op_t          kind;
        entry_t            entry;
        logic [TIME_W-1:0] now;
    } cell_ctrl_t;

endpackage

// ===== rtl/tdq_cell.sv =====
module tdq_cell
    import tdq_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int INDEX      = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cell_ctrl_t                         ctrl_i,
    input  logic [$clog2(NUM_TIMERS+1)-1:0]    append_count_i,
    input  logic                               up_valid_i,
    input  entry_t                             up_entry_i,
    input  logic                               down_valid_i,
    input  tok_t                               tok_i,
    output logic                               valid_o,
    output entry_t                             entry_o,
    output logic                               match_o,
    output tok_t                               tok_o
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    logic              valid_reg;
    logic              valid_next;
    entry_t            entry_reg;
    entry_t            entry_next;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] slack;
    logic              mine;

    assign valid_o = valid_reg;
    assign entry_o = entry_reg;
    assign tok_o   = tok_reg;
    assign match_o = valid_reg && (entry_reg.id == ctrl_i.entry.id);
    assign slack   = entry_reg.deadline - ctrl_i.now;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (ctrl_i.kind)
            CELL_REMOVE: begin
                if (match_o) begin
                    valid_next = 1'b0;
                end
            end
            CELL_COMPACT: begin
                if (!valid_reg && up_valid_i) begin
                    valid_next = 1'b1;
                    entry_next = up_entry_i;
                end else if (valid_reg && !down_valid_i) begin
                    valid_next = 1'b0;
                end
            end
            CELL_APPEND: begin
                if (append_count_i == CNT_W'(INDEX)) begin
                    valid_next = 1'b1;
                    entry_next = ctrl_i.entry;
                end
            end
            CELL_MARK: begin
                entry_next.due = valid_reg && slack[TIME_W-1];
            end
            default: begin
            end
        endcase
    end

    // keep the better of the incoming candidate and this entry; ties stay with the older one
    assign age  = ctrl_i.now - entry_reg.deadline;
    assign mine = valid_reg && entry_reg.due && (!tok_i.valid || (age > tok_i.age));

    always_comb begin
        tok_next = tok_i;
        if (mine) begin
            tok_next.valid    = 1'b1;
            tok_next.age      = age;
            tok_next.id       = entry_reg.id;
            tok_next.interval = entry_reg.interval;
            tok_next.periodic = entry_reg.periodic;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/tdq_ctrl.sv =====
module tdq_ctrl
    import tdq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [39:0]                        s_tdata,   // timer_id, interval_ms, periodic
    input  logic [1:0]                         s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // expired_id, rearmed
    output logic                               m_tlast,
    output cell_ctrl_t                         ctrl_o,
    output logic [$clog2(NUM_TIMERS+1)-1:0]    count_o,
    input  logic                               match_any_i,
    input  tok_t                               best_i
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] now_reg, now_next;
    entry_t            op_reg, op_next;
    logic              append_reg, append_next;
    logic              tick_reg, tick_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              pend_periodic_reg, pend_periodic_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_rearmed_reg, out_rearmed_next;
    logic              out_last_reg, out_last_next;

    logic [CMD_W-1:0]      in_cmd;
    logic [ID_W-1:0]       in_id;
    logic [INTERVAL_W-1:0] in_interval;
    logic                  in_periodic;
    logic                  id_ok;
    logic                  out_free;

    assign in_cmd      = s_tuser;
    assign in_id       = s_tdata[3:0];
    assign in_interval = s_tdata[34:4];
    assign in_periodic = s_tdata[35];
    assign id_ok       = 32'(in_id) < NUM_TIMERS;
    assign out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_rearmed_reg, out_id_reg};
    assign m_tlast  = out_last_reg;
    assign count_o  = count_reg;

    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        count_next         = count_reg;
        now_next           = now_reg;
        op_next            = op_reg;
        append_next        = append_reg;
        tick_next          = tick_reg;
        pend_valid_next    = pend_valid_reg;
        pend_id_next       = pend_id_reg;
        pend_periodic_next = pend_periodic_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_id_next        = out_id_reg;
        out_rearmed_next   = out_rearmed_reg;
        out_last_next      = out_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if ((in_cmd == CMD_ARM || in_cmd == CMD_DISARM) && id_ok) begin
                        op_next.id       = in_id;
                        op_next.deadline = now_reg + {1'b0, in_interval};
                        op_next.interval = in_interval;
                        op_next.periodic = in_periodic;
                        op_next.due      = 1'b0;
                        append_next      = (in_cmd == CMD_ARM);
                        tick_next        = 1'b0;
                        state_next       = ST_REMOVE;
                    end else if (in_cmd == CMD_TICK) begin
                        now_next   = now_reg + TIME_W'(1);
                        tick_next  = 1'b1;
                        state_next = ST_MARK;
                    end
                end
            end
            ST_REMOVE: begin
                count_next = count_reg - CNT_W'(match_any_i);
                cnt_next   = '0;
                state_next = ST_COMPACT;
            end
            ST_COMPACT: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_TIMERS - 1)) begin
                    cnt_next = '0;
                    if (append_reg) begin
                        state_next = ST_APPEND;
                    end else if (tick_reg) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_APPEND: begin
                count_next = count_reg + CNT_W'(1);
                cnt_next   = '0;
                state_next = tick_reg ? ST_SCAN : ST_IDLE;
            end
            ST_MARK: begin
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (cnt_reg != CNT_W'(NUM_TIMERS)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end else if (best_i.valid) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            out_valid_next   = 1'b1;
                            out_id_next      = pend_id_reg;
                            out_rearmed_next = pend_periodic_reg;
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next    = 1'b1;
                        pend_id_next       = best_i.id;
                        pend_periodic_next = best_i.periodic;
                        op_next.id         = best_i.id;
                        op_next.deadline   = now_reg + {1'b0, best_i.interval};
                        op_next.interval   = best_i.interval;
                        op_next.periodic   = best_i.periodic;
                        op_next.due        = 1'b0;
                        append_next        = best_i.periodic;
                        state_next         = ST_REMOVE;
                    end
                end else if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_id_next      = pend_id_reg;
                    out_rearmed_next = pend_periodic_reg;
                    out_last_next    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        ctrl_o.kind  = CELL_HOLD;
        ctrl_o.entry = op_reg;
        ctrl_o.now   = now_reg;
        case (state_reg)
            ST_IDLE:    s_tready    = 1'b1;
            ST_REMOVE:  ctrl_o.kind = CELL_REMOVE;
            ST_COMPACT: ctrl_o.kind = CELL_COMPACT;
            ST_APPEND:  ctrl_o.kind = CELL_APPEND;
            ST_MARK:    ctrl_o.kind = CELL_MARK;
            default:    ctrl_o.kind = CELL_HOLD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            count_reg      <= '0;
            now_reg        <= '0;
            append_reg     <= 1'b0;
            tick_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            append_reg     <= append_next;
            tick_reg       <= tick_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg            <= op_next;
        pend_id_reg       <= pend_id_next;
        pend_periodic_reg <= pend_periodic_next;
        out_id_reg        <= out_id_next;
        out_rearmed_reg   <= out_rearmed_next;
        out_last_reg      <= out_last_next;
    end

endmodule

// ===== rtl/timer_deadline_queue.sv =====
// Arm: remove, compaction across the cell chain, append, then ready again.
// Disarm: remove and compaction. Tick: mark and scan the chain once, then for each
// expiry remove, compaction, append (periodic only) and rescan, plus any output stall.
// One word at a time; a finished expiry waits in the pending, then the output register while work goes on.
// aresetn (synchronous, active low) clears time to zero and disarms every slot.
module timer_deadline_queue
    import tdq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // timer_id[3:0], interval_ms[34:4], periodic[35]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // expired_id[3:0], rearmed[4]
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    cell_ctrl_t             ctrl;
    logic [CNT_W-1:0]       count;
    logic [NUM_TIMERS-1:0]  valid_w;
    logic [NUM_TIMERS-1:0]  match_w;
    entry_t                 entry_w [NUM_TIMERS];
    tok_t                   tok_w   [NUM_TIMERS];

    tdq_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .ctrl_o      (ctrl),
        .count_o     (count),
        .match_any_i (|match_w),
        .best_i      (tok_w[NUM_TIMERS-1])
    );

    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
        logic   up_valid;
        entry_t up_entry;
        logic   down_valid;
        tok_t   tok_in;

        if (i == NUM_TIMERS - 1) begin : g_top
            assign up_valid = 1'b0;
            assign up_entry = '0;
        end else begin : g_mid
            assign up_valid = valid_w[i+1];
            assign up_entry = entry_w[i+1];
        end

        if (i == 0) begin : g_head
            assign down_valid = 1'b1;
            assign tok_in     = '0;
        end else begin : g_link
            assign down_valid = valid_w[i-1];
            assign tok_in     = tok_w[i-1];
        end

        tdq_cell #(
            .NUM_TIMERS (NUM_TIMERS),
            .INDEX      (i)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl_i         (ctrl),
            .append_count_i (count),
            .up_valid_i     (up_valid),
            .up_entry_i     (up_entry),
            .down_valid_i   (down_valid),
            .tok_i          (tok_in),
            .valid_o        (valid_w[i]),
            .entry_o        (entry_w[i]),
            .match_o        (match_w[i]),
            .tok_o          (tok_w[i])
        );
    end

endmodule
